@@ hdl/lzcam_pkg.sv @@
// Shared constants, codes and control/status types for the LZ dictionary CAM.
package lzcam_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = 8;
   localparam int SLOT_W   = 9;
   localparam int KEY_W    = 64;
   localparam int CNT_W    = 31;
   localparam int KIND_W   = 2;
   localparam int STAT_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 9;
   localparam int RSP_W    = 24;

   localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
   localparam logic [SLOT_W-1:0] CAP_SLOT = SLOT_W'(CAPACITY);

   localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_DROP = 2'd1;
   localparam logic [STAT_W-1:0] ST_DUP  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_DICT_SIZE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACE_START = 2'd2;

   typedef struct packed {
      logic             load;
      logic             match;
      logic             resolve;
      logic             write_key;
      logic [IDX_W-1:0] wr_idx;
      logic             fill_inc;
      logic             clear;
      logic             cnt_rd;
      logic [IDX_W-1:0] cnt_addr;
      logic             cnt_inc;
      logic             scan_init;
      logic             scan_eval;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [SLOT_W-1:0] fill;
      logic [SLOT_W-1:0] eff_size;
      logic              limit;
      logic [IDX_W-1:0]  rs;
      logic [IDX_W-1:0]  victim;
      logic              victim_valid;
      logic [SLOT_W-1:0] table_size;
   } stat_type;

endpackage

@@ hdl/lzcam_dp.sv @@
// Datapath: key store with parallel match, use counters, victim search, settings.
module lzcam_dp import lzcam_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [KEY_W-1:0]     req_tdata,
   input  logic [KIND_W-1:0]    req_tuser,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   input  cmd_type              cmd,
   output stat_type             stat
);

   logic [KEY_W-1:0]  key_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [SLOT_W-1:0] dict_size_ff;
   logic              limit_ff;
   logic [IDX_W-1:0]  rs_ff;
   logic [KEY_W-1:0]  entry_key_ff [CAPACITY];
   logic [CAPACITY-1:0] valid_ff;
   logic [CAPACITY-1:0] match_ff;
   logic [CAPACITY-1:0] cnt_ok_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [SLOT_W-1:0] fill_ff;
   logic [CNT_W-1:0]  cnt_mem [CAPACITY];
   logic [CNT_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]  rd_addr_ff;
   logic              rd_ok_ff;
   logic [CNT_W-1:0]  best_ff;
   logic [IDX_W-1:0]  victim_ff;

   logic [CAPACITY-1:0] match_in;
   logic              hit_in;
   logic [IDX_W-1:0]  hit_idx_in;
   logic [SLOT_W-1:0] eff_size;
   logic [CNT_W-1:0]  cnt_val;
   logic [CNT_W-1:0]  cnt_sat;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = valid_ff[i] && (entry_key_ff[i] == key_ff);
      end
   end

   always_comb begin
      hit_in     = 1'b0;
      hit_idx_in = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_in     = 1'b1;
            hit_idx_in = IDX_W'(i);
         end
      end
   end

   always_comb begin
      if (dict_size_ff == '0) begin
         eff_size = SLOT_W'(1);
      end else if (dict_size_ff > CAP_SLOT) begin
         eff_size = CAP_SLOT;
      end else begin
         eff_size = dict_size_ff;
      end
   end

   assign cnt_val = rd_ok_ff ? rd_data_ff : '0;
   assign cnt_sat = (cnt_val == CNT_MAX) ? cnt_val : cnt_val + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         dict_size_ff <= CAP_SLOT;
         limit_ff     <= 1'b1;
         rs_ff        <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_DICT_SIZE:     dict_size_ff <= csr_data;
            REG_SIZE_LIMIT:    limit_ff     <= csr_data[0];
            REG_REPLACE_START: rs_ff        <= csr_data[IDX_W-1:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         cnt_ok_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (cmd.clear) begin
            valid_ff <= '0;
            fill_ff  <= '0;
            if (limit_ff) begin
               cnt_ok_ff <= '0;
            end
         end
         if (cmd.write_key) begin
            valid_ff[cmd.wr_idx] <= 1'b1;
         end
         if (cmd.fill_inc) begin
            fill_ff <= fill_ff + SLOT_W'(1);
         end
         if (cmd.cnt_inc) begin
            cnt_ok_ff[rd_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff  <= req_tdata;
         kind_ff <= req_tuser;
      end
      if (cmd.match) begin
         match_ff <= match_in;
      end
      if (cmd.resolve) begin
         hit_ff     <= hit_in;
         hit_idx_ff <= hit_idx_in;
      end
      if (cmd.write_key) begin
         entry_key_ff[cmd.wr_idx] <= key_ff;
      end
      if (cmd.scan_init) begin
         best_ff   <= CNT_MAX;
         victim_ff <= rs_ff;
      end else if (cmd.scan_eval && (cnt_val < best_ff)) begin
         best_ff   <= cnt_val;
         victim_ff <= rd_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_rd) begin
         rd_data_ff <= cnt_mem[cmd.cnt_addr];
         rd_addr_ff <= cmd.cnt_addr;
         rd_ok_ff   <= cnt_ok_ff[cmd.cnt_addr];
      end
      if (cmd.cnt_inc) begin
         cnt_mem[rd_addr_ff] <= cnt_sat;
      end
   end

   assign stat.kind         = kind_ff;
   assign stat.hit          = hit_ff;
   assign stat.hit_idx      = hit_idx_ff;
   assign stat.fill         = fill_ff;
   assign stat.eff_size     = eff_size;
   assign stat.limit        = limit_ff;
   assign stat.rs           = rs_ff;
   assign stat.victim       = victim_ff;
   assign stat.victim_valid = valid_ff[victim_ff];
   assign stat.table_size   = limit_ff ? eff_size : fill_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_SLOT) else $error("fill count above capacity");
   a_no_write_on_clear: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear && cmd.write_key)) else $error("key write during clear");
   a_victim_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_eval |=> victim_ff >= rs_ff) else $error("victim below start");

endmodule

@@ hdl/lzcam_ctrl.sv @@
// Controller: request sequencing, insert/replace decisions and response register.
module lzcam_ctrl import lzcam_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   input  stat_type         stat,
   output cmd_type          cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_MATCH, S_PRIO, S_DEC, S_BUMP, S_SCAN0, S_SCAN, S_REPL
   } state_type;

   state_type         state_ff, state_in;
   logic              found_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              replaced_ff;
   logic [STAT_W-1:0] status_ff;
   logic [IDX_W-1:0]  scan_ff;
   logic              done_ff;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   logic [IDX_W-1:0]  last_idx;
   logic              room;
   logic              out_free;

   assign last_idx  = stat.eff_size[IDX_W-1:0] - IDX_W'(1);
   assign room      = stat.fill < stat.eff_size;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !done_ff;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      cmd.load  = req_tvalid && req_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = S_PRIO;
         end
         S_PRIO: begin
            cmd.resolve = 1'b1;
            state_in    = S_DEC;
         end
         S_DEC: begin
            state_in = S_IDLE;
            case (stat.kind)
               KIND_FIND: begin
                  if (stat.hit && stat.limit) begin
                     cmd.cnt_rd   = 1'b1;
                     cmd.cnt_addr = stat.hit_idx;
                     state_in     = S_BUMP;
                  end
               end
               KIND_INSERT: begin
                  if (!stat.hit) begin
                     if (!stat.limit) begin
                        if (stat.fill < CAP_SLOT) begin
                           cmd.write_key = 1'b1;
                           cmd.wr_idx    = stat.fill[IDX_W-1:0];
                           cmd.fill_inc  = 1'b1;
                        end
                     end else if (room) begin
                        cmd.write_key = 1'b1;
                        cmd.wr_idx    = stat.fill[IDX_W-1:0];
                        cmd.fill_inc  = 1'b1;
                        cmd.cnt_rd    = 1'b1;
                        cmd.cnt_addr  = stat.fill[IDX_W-1:0];
                        state_in      = S_BUMP;
                     end else if ({1'b0, stat.rs} < stat.eff_size) begin
                        state_in = S_SCAN0;
                     end
                  end
               end
               KIND_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               default: ;
            endcase
         end
         S_BUMP: begin
            cmd.cnt_inc = 1'b1;
            state_in    = S_IDLE;
         end
         S_SCAN0: begin
            cmd.scan_init = 1'b1;
            cmd.cnt_rd    = 1'b1;
            cmd.cnt_addr  = stat.rs;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_eval = 1'b1;
            if (scan_ff == last_idx) begin
               state_in = S_REPL;
            end else begin
               cmd.cnt_rd   = 1'b1;
               cmd.cnt_addr = scan_ff + IDX_W'(1);
            end
         end
         S_REPL: begin
            cmd.write_key = 1'b1;
            cmd.wr_idx    = stat.victim;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (done_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= {2'b00, status_ff, stat.table_size, replaced_ff, slot_ff,
                             found_ff};
            done_ff      <= 1'b0;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_DEC: begin
               found_ff    <= 1'b0;
               slot_ff     <= '0;
               replaced_ff <= 1'b0;
               status_ff   <= ST_OK;
               done_ff     <= (state_in == S_IDLE);
               case (stat.kind)
                  KIND_FIND: begin
                     if (stat.hit) begin
                        found_ff <= 1'b1;
                        slot_ff  <= {1'b0, stat.hit_idx} + SLOT_W'(1);
                     end
                  end
                  KIND_INSERT: begin
                     if (stat.hit) begin
                        slot_ff   <= {1'b0, stat.hit_idx} + SLOT_W'(1);
                        status_ff <= ST_DUP;
                     end else if (!stat.limit) begin
                        if (stat.fill < CAP_SLOT) begin
                           slot_ff <= stat.fill + SLOT_W'(1);
                        end else begin
                           status_ff <= ST_DROP;
                        end
                     end else if (room) begin
                        slot_ff <= stat.fill + SLOT_W'(1);
                     end else if ({1'b0, stat.rs} >= stat.eff_size) begin
                        status_ff <= ST_DROP;
                     end
                  end
                  default: ;
               endcase
            end
            S_BUMP: done_ff <= 1'b1;
            S_SCAN0: scan_ff <= stat.rs;
            S_SCAN: scan_ff <= scan_ff + IDX_W'(1);
            S_REPL: begin
               replaced_ff <= stat.victim_valid;
               slot_ff     <= {1'b0, stat.victim} + SLOT_W'(1);
               done_ff     <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(done_ff)) else $error("response without finished request");
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("request taken while busy");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> scan_ff <= last_idx) else $error("scan past table size");

endmodule

@@ hdl/lz_dictionary_cam_lfu.sv @@
// Top level of the LZ dictionary CAM with least-frequently-used replacement.
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata: key[63:0]; tuser: kind[1:0]
//  rsp      out  rsp_tvalid/rsp_tready  tdata: found, slot, replaced, table_size, status
//  csr      in   csr_valid/csr_ready    csr_index[1:0], csr_data[8:0]
//
//  A find or insert passes MATCH, PRIO, DEC, and BUMP for a counter update; a full-table
//  insert adds SCAN0, one SCAN per counter read from the one-port memory, and REPL.
//  Reset is synchronous; the table starts empty with all counters zero.
//  One request is in flight; the next is taken once the result is in the
//  output register, which holds it while rsp_tready is low.
module lz_dictionary_cam_lfu import lzcam_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [KEY_W-1:0]     req_tdata,  // key[63:0]
   input  logic [KIND_W-1:0]    req_tuser,  // kind[1:0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,  // found, slot[9], replaced, table_size[9], status[2]
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   lzcam_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .stat       (stat),
      .cmd        (cmd)
   );

   lzcam_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
